// ===== sv/sactc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the set-associative cache tag controller.
// No dependencies.
package sactc_pkg;

  localparam int WAYS         = 8;
  localparam int MAX_SET_BITS = 6;
  localparam int ADDR_BITS    = 32;
  localparam int NSETS        = 1 << MAX_SET_BITS;
  localparam int WAY_W        = 3;
  localparam int CNT_W        = 32;
  localparam int TAG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 4;
  localparam int MAX_OFFSET   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WT_MODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_WRITE   = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stamp;
    logic [CNT_W-1:0] uses;
  } line_t;

  typedef struct packed {
    logic [CNT_W-1:0]     cnt;
    line_t [WAYS-1:0]     line;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic load;
    logic latch;
    logic eval;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } status_t;

endpackage

// ===== sv/sactc_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the cache tag controller: request, response, config.
// No dependencies.
interface sactc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] addr;
  modport source (output valid, op, addr, input ready);
  modport sink (input valid, op, addr, output ready);
endinterface

interface sactc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        fill_request;
  logic        writeback_valid;
  logic [31:0] writeback_addr;
  logic        forward_write;
  logic [2:0]  line_way;
  modport source (output valid, hit, fill_request, writeback_valid, writeback_addr,
                  forward_write, line_way, input ready);
  modport sink (input valid, hit, fill_request, writeback_valid, writeback_addr,
                forward_write, line_way, output ready);
endinterface

interface sactc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] idx;
  logic [3:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// ===== sv/sactc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module sactc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/sactc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, set row store, hit/empty search, victim scan, update.
// Depends on sactc_pkg and sactc_ram.
module sactc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sactc_pkg::cmd_t                  cmd,
  output sactc_pkg::status_t               status,
  input  logic                             cfg_we,
  input  logic [sactc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sactc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_op,
  input  logic [31:0]                      in_addr,
  output logic                             hit,
  output logic                             fill_request,
  output logic                             writeback_valid,
  output logic [31:0]                      writeback_addr,
  output logic                             forward_write,
  output logic [2:0]                       line_way
);
  import sactc_pkg::*;

  logic [3:0] offset_bits;
  logic [2:0] index_bits;
  logic [3:0] ways_in_use;
  logic       replace_mode;
  logic       wt_mode;
  logic       alloc_write;

  logic [3:0]              b;
  logic [2:0]              s;
  logic [3:0]              nw;
  logic                    op;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [TAG_W-1:0]        tag;
  logic [NSETS-1:0]        row_vld;
  logic [ROW_W-1:0]        ram_q;
  row_t                    row;
  row_t                    row_next;
  logic                    ram_we;
  logic [WAYS-1:0]         hit_vec;
  logic [WAYS-1:0]         empty_vec;
  logic [WAY_W-1:0]        hit_way;
  logic [WAY_W-1:0]        empty_way;
  logic                    any_hit;
  logic                    any_empty;
  logic                    bypass_now;
  logic                    hit_q;
  logic                    bypass_q;
  logic                    full_q;
  logic [WAY_W-1:0]        vw;
  logic [WAY_W-1:0]        sw;
  logic                    better;
  logic                    is_write;
  logic [CNT_W-1:0]        cnt_inc;
  line_t                   vline;
  logic [4:0]              sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits   <= 4'd6;
      index_bits    <= 3'd6;
      ways_in_use   <= 4'd8;
      replace_mode  <= 1'b0;
      wt_mode       <= 1'b0;
      alloc_write   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OFFSET_BITS:   offset_bits   <= cfg_data;
        REG_INDEX_BITS:    index_bits    <= cfg_data[2:0];
        REG_WAYS_IN_USE:   ways_in_use   <= cfg_data;
        REG_REPLACE_MODE:  replace_mode  <= cfg_data[0];
        REG_WT_MODE:       wt_mode       <= cfg_data[0];
        REG_ALLOC_WRITE:   alloc_write   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign b  = (offset_bits > 4'(MAX_OFFSET)) ? 4'(MAX_OFFSET) : offset_bits;
  assign s  = (index_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : index_bits;
  assign nw = (ways_in_use == 4'd0) ? 4'd1 :
              ((ways_in_use > 4'(WAYS)) ? 4'(WAYS) : ways_in_use);
  assign sh = 5'(b) + 5'(s);
  assign is_write = (op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_op;
      set_idx <= MAX_SET_BITS'((in_addr >> b) & ((32'd1 << s) - 32'd1));
      tag     <= TAG_W'(in_addr >> (5'(b) + 5'(s)));
    end
  end

  sactc_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (set_idx),
    .wdata (row_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (ram_we) begin
      row_vld[set_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row <= row_vld[set_idx] ? row_t'(ram_q) : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i]   = (4'(i) < nw) && row.line[i].valid && (row.line[i].tag == tag);
      empty_vec[i] = (4'(i) < nw) && !row.line[i].valid;
    end
    hit_way   = '0;
    empty_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (empty_vec[i]) begin
        empty_way = WAY_W'(i);
      end
    end
  end

  assign any_hit    = |hit_vec;
  assign any_empty  = |empty_vec;
  assign bypass_now = !any_hit && is_write && !alloc_write;

  assign status.need_scan = !any_hit && !bypass_now && !any_empty && (nw > 4'd1);
  assign status.scan_last = ({1'b0, sw} + 4'd1) >= nw;

  assign better = replace_mode ? (row.line[sw].uses < row.line[vw].uses)
                               : (row.line[sw].stamp < row.line[vw].stamp);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_q    <= any_hit;
      bypass_q <= bypass_now;
      full_q   <= !any_hit && !any_empty;
      sw       <= WAY_W'(1);
      vw       <= any_hit ? hit_way : (any_empty ? empty_way : '0);
    end else if (cmd.step) begin
      if (better) begin
        vw <= sw;
      end
      sw <= sw + WAY_W'(1);
    end
  end

  assign vline   = row.line[vw];
  assign cnt_inc = row.cnt + CNT_W'(1);

  always_comb begin
    row_next          = row;
    row_next.cnt      = cnt_inc;
    if (hit_q) begin
      row_next.line[vw].uses  = vline.uses + CNT_W'(1);
      row_next.line[vw].stamp = cnt_inc;
      if (is_write && !wt_mode) begin
        row_next.line[vw].dirty = 1'b1;
      end
    end else begin
      row_next.line[vw].valid = 1'b1;
      row_next.line[vw].dirty = is_write && !wt_mode;
      row_next.line[vw].tag   = tag;
      row_next.line[vw].uses  = CNT_W'(1);
      row_next.line[vw].stamp = cnt_inc;
    end
  end

  assign ram_we = cmd.commit && !bypass_q;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit             <= hit_q;
      fill_request    <= !hit_q && !bypass_q;
      writeback_valid <= !hit_q && !bypass_q && full_q && vline.dirty;
      writeback_addr  <= (!hit_q && !bypass_q && full_q && vline.dirty) ?
                         ((32'(vline.tag) << sh) | (32'(set_idx) << b)) : 32'd0;
      forward_write   <= is_write && (bypass_q || wt_mode);
      line_way        <= bypass_q ? 3'd0 : vw;
    end
  end

endmodule

// ===== sv/sactc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing read, search, victim scan, update and response.
// Depends on sactc_pkg.
module sactc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sactc_pkg::cmd_t     cmd,
  input  sactc_pkg::status_t  status
);
  import sactc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_LATCH  = 7'b0000100,
    S_EVAL   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// ===== sv/set_assoc_cache_tag_controller.sv =====
`timescale 1ns / 1ps
// Top level of the set-associative cache tag controller.
// Depends on sactc_pkg, sactc_if, sactc_ctrl, sactc_dp.
//
//   channel | dir | payload
//   cfg     | in  | idx, data (register write)
//   req     | in  | op, addr
//   rsp     | out | hit, fill_request, writeback_valid, writeback_addr,
//           |     | forward_write, line_way
//
// A response is offered after the set row RAM read, the row latch, the hit and empty search
// and, when a full set must be replaced, a victim scan over each used way beyond the first,
// then the commit; the next request can be taken in the cycle after the response is taken.
// The registered set row RAM read and the single-way victim comparator set this sequence.
// Synchronous reset restores the default configuration, clears set row valid bits and resets the controller.
// A stalled response holds the block; cfg is always ready.
module set_assoc_cache_tag_controller (
  input  logic        clk,
  input  logic        rst,
  sactc_cfg_if.sink   cfg,
  sactc_req_if.sink   req,
  sactc_rsp_if.source rsp
);
  import sactc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  sactc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  sactc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg.valid),
    .cfg_idx         (cfg.idx),
    .cfg_data        (cfg.data),
    .in_op           (req.op),
    .in_addr         (req.addr),
    .hit             (rsp.hit),
    .fill_request    (rsp.fill_request),
    .writeback_valid (rsp.writeback_valid),
    .writeback_addr  (rsp.writeback_addr),
    .forward_write   (rsp.forward_write),
    .line_way        (rsp.line_way)
  );

endmodule

// ===== sv/sactc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the cache tag controller, bound to the top level.
// Depends on set_assoc_cache_tag_controller.
module sactc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       hit,
  input logic       fill_request,
  input logic       writeback_valid,
  input logic       forward_write,
  input logic [2:0] line_way
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while response pending");

  a_no_fast_rsp: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("response too soon after request transaction");

  a_hit_xor_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && fill_request))
    else $error("hit and fill together");

  a_wb_needs_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && writeback_valid) |-> fill_request)
    else $error("write-back without fill");

  a_bypass_way: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit && !fill_request) |-> (forward_write && line_way == 3'd0))
    else $error("untouched access reports a way");

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .hit             (rsp.hit),
  .fill_request    (rsp.fill_request),
  .writeback_valid (rsp.writeback_valid),
  .forward_write   (rsp.forward_write),
  .line_way        (rsp.line_way)
);

// ===== bench/set_assoc_cache_tag_controller_test.sv =====
`timescale 1ns / 1ps
// Testbench for the set-associative cache tag controller: a directed table and random accesses,
// each result checked against a behavioral model. Depends on sactc_pkg, sactc_if, the top level.
module set_assoc_cache_tag_controller_test;
  import sactc_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        fill_request;
    logic        writeback_valid;
    logic [31:0] writeback_addr;
    logic        forward_write;
    logic [2:0]  line_way;
  } access_result_t;

  typedef struct {
    logic        op;
    logic [31:0] addr;
    bit          typed;
    access_result_t res;
  } access_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  sactc_cfg_if cfg ();
  sactc_req_if req ();
  sactc_rsp_if rsp ();

  set_assoc_cache_tag_controller i_dut (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));

  bit          m_valid [NSETS*WAYS];
  bit          m_dirty [NSETS*WAYS];
  logic [31:0] m_tag   [NSETS*WAYS];
  logic [31:0] m_stamp [NSETS*WAYS];
  logic [31:0] m_uses  [NSETS*WAYS];
  logic [31:0] m_cnt   [NSETS];
  logic [3:0]  c_off, c_ways;
  logic [2:0]  c_idx;
  bit          c_lfu, c_wt, c_alloc;

  access_result_t pending_results[$];
  bit             pending_typed[$];
  access_result_t typed_results[$];
  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 19;
  int  recv_idle = 61;

  function automatic access_result_t cache_access(logic op, logic [31:0] addr);
    access_result_t r;
    int b, s, nw, set, base, w, vw, i;
    bit found, empty, better;
    logic [31:0] tag;
    logic [63:0] wa;
    r = '0;
    b = (c_off > MAX_OFFSET) ? MAX_OFFSET : c_off;
    s = (c_idx > MAX_SET_BITS) ? MAX_SET_BITS : c_idx;
    nw = (c_ways == 0) ? 1 : ((c_ways > WAYS) ? WAYS : c_ways);
    set = int'((addr >> b) & ((32'd1 << s) - 1));
    tag = 32'(64'(addr) >> (b + s));
    base = set * WAYS;
    found = 0;
    vw = 0;
    for (w = 0; w < nw; w++)
      if (!found && m_valid[base+w] && m_tag[base+w] == tag) begin
        found = 1;
        vw = w;
      end
    if (found) begin
      i = base + vw;
      r.hit = 1;
      r.line_way = vw[2:0];
      m_uses[i] = m_uses[i] + 1;
      m_cnt[set] = m_cnt[set] + 1;
      m_stamp[i] = m_cnt[set];
      if (op == OP_WRITE) begin
        if (c_wt) r.forward_write = 1;
        else m_dirty[i] = 1;
      end
    end else if (op == OP_WRITE && !c_alloc) begin
      r.forward_write = 1;
    end else begin
      empty = 0;
      for (w = 0; w < nw; w++)
        if (!empty && !m_valid[base+w]) begin
          empty = 1;
          vw = w;
        end
      if (!empty) begin
        vw = 0;
        for (w = 1; w < nw; w++) begin
          better = c_lfu ? (m_uses[base+w] < m_uses[base+vw])
                         : (m_stamp[base+w] < m_stamp[base+vw]);
          if (better) vw = w;
        end
        if (m_dirty[base+vw]) begin
          wa = (64'(m_tag[base+vw]) << (b + s)) | (64'(set) << b);
          r.writeback_valid = 1;
          r.writeback_addr = wa[31:0];
        end
      end
      i = base + vw;
      r.fill_request = 1;
      r.line_way = vw[2:0];
      m_valid[i] = 1;
      m_dirty[i] = 0;
      m_tag[i] = tag;
      m_uses[i] = 1;
      m_cnt[set] = m_cnt[set] + 1;
      m_stamp[i] = m_cnt[set];
      if (op == OP_WRITE) begin
        if (c_wt) r.forward_write = 1;
        else m_dirty[i] = 1;
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [3:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.idx <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_OFFSET_BITS:   c_off = data;
      REG_INDEX_BITS:    c_idx = data[2:0];
      REG_WAYS_IN_USE:   c_ways = data;
      REG_REPLACE_MODE:  c_lfu = data[0];
      REG_WT_MODE:       c_wt = data[0];
      REG_ALLOC_WRITE:   c_alloc = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_access(logic op, logic [31:0] addr, bit typed, access_result_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.addr <= addr;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(cache_access(op, addr));
    pending_typed.push_back(typed);
    if (typed) typed_results.push_back(res);
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_mode(int off, int idx, int ways, bit lfu, bit wt, bit alloc);
    drain();
    write_reg(REG_OFFSET_BITS, 4'(off));
    write_reg(REG_INDEX_BITS, 4'(idx));
    write_reg(REG_WAYS_IN_USE, 4'(ways));
    write_reg(REG_REPLACE_MODE, 4'(lfu));
    write_reg(REG_WT_MODE, 4'(wt));
    write_reg(REG_ALLOC_WRITE, 4'(alloc));
  endtask

  always @(negedge clk) rsp.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    access_result_t exp_r, ref_r;
    bit typed;
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b way=%0d", $time, rsp.hit, rsp.line_way);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        typed = pending_typed.pop_front();
        if (typed) begin
          ref_r = typed_results.pop_front();
          if (ref_r != exp_r) begin
            $display("%0t: table row expected %h, model %h", $time, ref_r, exp_r);
            errors++;
          end
        end
        if (exp_r.hit != rsp.hit || exp_r.fill_request != rsp.fill_request ||
            exp_r.writeback_valid != rsp.writeback_valid ||
            exp_r.writeback_addr != rsp.writeback_addr ||
            exp_r.forward_write != rsp.forward_write || exp_r.line_way != rsp.line_way) begin
          $display("%0t: expected hit=%0b fill=%0b wb=%0b wba=%h fwd=%0b way=%0d", $time,
                   exp_r.hit, exp_r.fill_request, exp_r.writeback_valid, exp_r.writeback_addr,
                   exp_r.forward_write, exp_r.line_way);
          $display("%0t: actual   hit=%0b fill=%0b wb=%0b wba=%h fwd=%0b way=%0d", $time,
                   rsp.hit, rsp.fill_request, rsp.writeback_valid, rsp.writeback_addr,
                   rsp.forward_write, rsp.line_way);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 1500000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic access_result_t mk(bit h, bit f, bit wb, logic [31:0] wa, bit fw,
                                        logic [2:0] w);
    access_result_t r;
    r.hit = h;
    r.fill_request = f;
    r.writeback_valid = wb;
    r.writeback_addr = wa;
    r.forward_write = fw;
    r.line_way = w;
    return r;
  endfunction

  task automatic run_random(int count, logic [31:0] tag_mask);
    int k;
    logic [31:0] a;
    for (k = 0; k < count; k++) begin
      a = $urandom();
      if ($urandom_range(9) < 8) a = a & tag_mask;
      send_access(logic'($urandom_range(1)), a, 1'b0, '0);
    end
  endtask

  initial begin
    access_row_t table_rows[$];
    access_row_t row;
    int n, k;
    cfg.valid = 1'b0;
    cfg.idx = '0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.op = OP_READ;
    req.addr = '0;
    for (n = 0; n < NSETS*WAYS; n++) begin
      m_valid[n] = 0; m_dirty[n] = 0; m_tag[n] = 0; m_stamp[n] = 0; m_uses[n] = 0;
    end
    for (n = 0; n < NSETS; n++) m_cnt[n] = 0;
    c_off = 6; c_idx = 6; c_ways = 8; c_lfu = 0; c_wt = 0; c_alloc = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: default geometry, write-back, write-allocate
    row.typed = 1'b1; row.op = OP_READ; row.addr = 32'h0000_0000;
    row.res = mk(1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 3'd0); table_rows.push_back(row);
    row.op = OP_READ; row.addr = 32'h0000_003F;
    row.res = mk(1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    table_rows.push_back(row);
    row.op = OP_WRITE; row.addr = 32'hFFFF_FFFF;
    row.res = mk(1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 3'd0);
    table_rows.push_back(row);
    row.op = OP_WRITE; row.addr = 32'h0000_0000;
    row.res = mk(1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 3'd0);
    table_rows.push_back(row);
    row.typed = 1'b0;
    for (n = 1; n <= 8; n++) begin
      row.op = OP_READ; row.addr = 32'(n) << 12; table_rows.push_back(row);
    end
    for (n = 0; n < table_rows.size(); n++)
      send_access(table_rows[n].op, table_rows[n].addr, table_rows[n].typed, table_rows[n].res);

    // one way, write-through, no allocate; offset and index out of range
    set_mode(15, 7, 0, 1'b0, 1'b1, 1'b0);
    table_rows.delete();
    row.typed = 1'b1;
    row.op = OP_WRITE; row.addr = 32'hABCD_0000;
    row.res = mk(1'b0, 1'b0, 1'b0, 32'd0, 1'b1, 3'd0);
    table_rows.push_back(row);
    row.op = OP_READ; row.addr = 32'h0000_0000;
    row.res = mk(1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 3'd0);
    table_rows.push_back(row);
    row.typed = 1'b0;
    row.op = OP_WRITE; row.addr = 32'h0000_0FFF; table_rows.push_back(row);
    row.op = OP_READ; row.addr = 32'hFFFF_FFFF; table_rows.push_back(row);
    row.op = OP_READ; row.addr = 32'h8000_0000; table_rows.push_back(row);
    for (n = 0; n < table_rows.size(); n++)
      send_access(table_rows[n].op, table_rows[n].addr, table_rows[n].typed, table_rows[n].res);

    for (k = 0; k < 3; k++) begin
      if (k == 1) begin send_idle = 61; recv_idle = 19; end
      if (k == 2) begin send_idle = 0; recv_idle = 0; end
      set_mode(0, 0, 8, 1'b0, 1'b0, 1'b1);
      run_random(100, 32'h0000_000F);
      set_mode(12, 6, 15, 1'b1, 1'b0, 1'b1);
      run_random(100, 32'h0007_FFFF);
      set_mode(4, 2, 3, 1'b0, 1'b1, 1'b1);
      run_random(100, 32'h0000_07FF);
      set_mode(2, 1, 2, 1'b1, 1'b0, 1'b0);
      run_random(100, 32'h0000_00FF);
      set_mode(int'($urandom_range(12)), int'($urandom_range(6)), int'($urandom_range(1, 8)),
               1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      run_random(200, 32'h0000_3FFF);
    end
    drain();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
